>>> design/assert_macros.svh
// Shared concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, live during reset too
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/psm_pkg.sv
`default_nettype none

package psm_pkg;

  localparam int COORD_WIDTH       = 20;
  localparam int COORD_FRAC_BITS   = 10;
  localparam int INVERSE_FRAC_BITS = 16;
  localparam int TOL_WIDTH         = 32;
  localparam int TOL_FRAC_BITS     = 20;
  localparam int NUM_AXES          = 3;
  localparam int CFG_INDEX_WIDTH   = 3;
  localparam int CFG_DATA_WIDTH    = NUM_AXES * COORD_WIDTH;

  // fraction bits of fractional coordinates
  localparam int FSH    = COORD_FRAC_BITS + INVERSE_FRAC_BITS;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int P1_W   = COORD_WIDTH + DIFF_W;
  localparam int F_W    = P1_W + 2;
  // reduced fraction lies in [-1/2, 1/2]
  localparam int R_W    = FSH + 1;
  localparam int P2_W   = COORD_WIDTH + R_W;
  localparam int ACC_W  = P2_W + 2;
  localparam int MAG_W  = ACC_W;
  localparam int C_W    = MAG_W + 1 - FSH;
  localparam int SQ_W   = 2 * C_W;
  localparam int SUM_W  = SQ_W + 2;

  localparam int TOL_SHIFT = (2 * COORD_FRAC_BITS >= TOL_FRAC_BITS) ?
                             2 * COORD_FRAC_BITS - TOL_FRAC_BITS : 0;
  localparam int SUM_SHIFT = (2 * COORD_FRAC_BITS >= TOL_FRAC_BITS) ?
                             0 : TOL_FRAC_BITS - 2 * COORD_FRAC_BITS;
  localparam int CMP_W = (SUM_W + SUM_SHIFT > TOL_WIDTH + TOL_SHIFT) ?
                         SUM_W + SUM_SHIFT : TOL_WIDTH + TOL_SHIFT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LATTICE_ROW_0,
    REG_LATTICE_ROW_1,
    REG_LATTICE_ROW_2,
    REG_INVERSE_ROW_0,
    REG_INVERSE_ROW_1,
    REG_INVERSE_ROW_2,
    REG_REFERENCE_POSITION,
    REG_TOLERANCE_SQUARED
  } cfg_reg_t;

  typedef struct packed {
    coord_t [NUM_AXES-1:0][NUM_AXES-1:0] lattice;
    coord_t [NUM_AXES-1:0][NUM_AXES-1:0] inverse;
    coord_t [NUM_AXES-1:0]               ref_pos;
    logic   [TOL_WIDTH-1:0]              tol;
  } psm_cfg_t;

endpackage

`default_nettype wire

>>> design/psm_if.sv
`default_nettype none

interface psm_pos_if import psm_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t position_x;
  coord_t position_y;
  coord_t position_z;

  modport source (output valid, output position_x, output position_y,
                  output position_z, input ready);
  modport sink   (input valid, input position_x, input position_y,
                  input position_z, output ready);
endinterface

interface psm_match_if ();
  logic valid;
  logic ready;
  logic is_match;

  modport source (output valid, output is_match, input ready);
  modport sink   (input valid, input is_match, output ready);
endinterface

interface psm_cfg_if import psm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/psm_cfg_regs.sv
`default_nettype none

module psm_cfg_regs import psm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  psm_cfg_if.sink   cfg,
  output psm_cfg_t  regs
);

  coord_t [NUM_AXES-1:0] row;

  assign cfg.ready = 1'b1;

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      row[j] = cfg.data[j*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_LATTICE_ROW_0:      regs.lattice[0] <= row;
        REG_LATTICE_ROW_1:      regs.lattice[1] <= row;
        REG_LATTICE_ROW_2:      regs.lattice[2] <= row;
        REG_INVERSE_ROW_0:      regs.inverse[0] <= row;
        REG_INVERSE_ROW_1:      regs.inverse[1] <= row;
        REG_INVERSE_ROW_2:      regs.inverse[2] <= row;
        REG_REFERENCE_POSITION: regs.ref_pos    <= row;
        REG_TOLERANCE_SQUARED:  regs.tol        <= cfg.data[TOL_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/periodic_site_match.sv
// Position beats pass through stages d, p1, r, p2, mag, cmag, sq and match.
// Throughput: one position per cycle unless stalled; a stalled result holds
// only the stages behind it, and empty stages keep filling (per-stage
// valid/ready chain). Each matrix product's nine multipliers share a stage.
// Reset (sync, active high) clears stage valids and all config registers.
`default_nettype none

module periodic_site_match import psm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  psm_pos_if.sink     site,
  psm_match_if.source result,
  psm_cfg_if.sink     cfg
);

  localparam int NUM_STAGES = 8;
  localparam logic [FSH-1:0] RND_HALF = {1'b1, {(FSH-1){1'b0}}};

  psm_cfg_t creg;

  psm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (creg)
  );

  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !v[NUM_STAGES] || result.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign site.ready      = en[1];
  assign result.valid    = v[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= site.valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage registers
  logic signed [DIFF_W-1:0] d    [NUM_AXES];
  logic signed [P1_W-1:0]   p1   [NUM_AXES][NUM_AXES];
  logic signed [R_W-1:0]    r    [NUM_AXES];
  logic signed [P2_W-1:0]   p2   [NUM_AXES][NUM_AXES];
  logic [MAG_W-1:0]         mag  [NUM_AXES];
  logic [C_W-1:0]           cmag [NUM_AXES];
  logic [SQ_W-1:0]          sq   [NUM_AXES];
  logic                     match;

  logic signed [DIFF_W-1:0] d_next    [NUM_AXES];
  logic signed [P1_W-1:0]   p1_next   [NUM_AXES][NUM_AXES];
  logic signed [R_W-1:0]    r_next    [NUM_AXES];
  logic signed [P2_W-1:0]   p2_next   [NUM_AXES][NUM_AXES];
  logic [MAG_W-1:0]         mag_next  [NUM_AXES];
  logic [C_W-1:0]           cmag_next [NUM_AXES];
  logic [SQ_W-1:0]          sq_next   [NUM_AXES];
  logic                     match_next;

  coord_t                   pos  [NUM_AXES];
  logic signed [F_W-1:0]    f    [NUM_AXES];
  logic [FSH-1:0]           frac [NUM_AXES];
  logic                     wrap [NUM_AXES];
  logic signed [ACC_W-1:0]  acc  [NUM_AXES];
  logic [MAG_W:0]           rnd  [NUM_AXES];
  logic [SUM_W-1:0]         sum;

  assign pos[0] = site.position_x;
  assign pos[1] = site.position_y;
  assign pos[2] = site.position_z;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      d_next[i] = DIFF_W'($signed(creg.ref_pos[i])) - DIFF_W'(pos[i]);

      for (int j = 0; j < NUM_AXES; j++) begin
        p1_next[i][j] = P1_W'($signed(creg.inverse[i][j])) * P1_W'(d[j]);
      end

      // reduce by nearest integer, ties away from zero: keep the fraction
      // bits and pick the sign that puts the remainder in [-1/2, 1/2]
      f[i] = F_W'(p1[i][0]) + F_W'(p1[i][1]) + F_W'(p1[i][2]);
      frac[i] = f[i][FSH-1:0];
      wrap[i] = (frac[i] > RND_HALF) || (frac[i] == RND_HALF && !f[i][F_W-1]);
      r_next[i] = $signed({wrap[i], frac[i]});

      for (int j = 0; j < NUM_AXES; j++) begin
        p2_next[i][j] = P2_W'($signed(creg.lattice[i][j])) * P2_W'(r[j]);
      end

      acc[i] = ACC_W'(p2[i][0]) + ACC_W'(p2[i][1]) + ACC_W'(p2[i][2]);
      mag_next[i] = acc[i][ACC_W-1] ? MAG_W'(~acc[i] + 1'b1) : MAG_W'(acc[i]);

      rnd[i] = {1'b0, mag[i]} + (MAG_W+1)'(RND_HALF);
      cmag_next[i] = rnd[i][MAG_W:FSH];

      sq_next[i] = SQ_W'(cmag[i]) * SQ_W'(cmag[i]);
    end

    sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    match_next = (CMP_W'(sum) << SUM_SHIFT) < (CMP_W'(creg.tol) << TOL_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[1]) d <= d_next;
    if (en[2]) p1 <= p1_next;
    if (en[3]) r <= r_next;
    if (en[4]) p2 <= p2_next;
    if (en[5]) mag <= mag_next;
    if (en[6]) cmag <= cmag_next;
    if (en[7]) sq <= sq_next;
    if (en[8]) match <= match_next;
  end

  assign result.is_match = match;

endmodule

`default_nettype wire

>>> design/psm_checker.sv
`default_nettype none
`include "assert_macros.svh"

module psm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic site_valid,
  input wire logic site_ready,
  input wire logic result_valid,
  input wire logic result_ready,
  input wire logic is_match
);

  // a held result beat keeps its value
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(is_match))

  // nothing comes out of a freshly reset pipeline
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !result_valid)

  // a flowing output never back-pressures the input
  `ASSERT_IMPLIES(a_flow_ready, clk, rst, !result_valid || result_ready, site_ready)

  // no result beat appears once no position has been offered for long enough to empty the pipeline
  `ASSERT_NEXT(a_no_spurious, clk, rst, !site_valid && !result_valid && $past(!site_valid, 1) && $past(!site_valid, 2) && $past(!site_valid, 3) && $past(!site_valid, 4) && $past(!site_valid, 5) && $past(!site_valid, 6) && $past(!site_valid, 7) && $past(!rst, 8), !result_valid)

endmodule

bind periodic_site_match psm_checker u_psm_checker (
  .clk          (clk),
  .rst          (rst),
  .site_valid   (site.valid),
  .site_ready   (site.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .is_match     (result.is_match)
);

`default_nettype wire

>>> tb/sv/site_match_checker.sv
`default_nettype none

module site_match_checker import psm_pkg::*; (
  input  logic clk,
  input  logic rst,
  psm_pos_if   site,
  psm_match_if result,
  psm_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);

  localparam int NUM_REGS = 8;
  localparam int FRAC_SUM = COORD_FRAC_BITS + INVERSE_FRAC_BITS;

  logic [CFG_DATA_WIDTH-1:0] regs [NUM_REGS];
  bit expected_match [$];

  function automatic longint reg_field(int r, int j);
    coord_t e;
    e = regs[r][j*COORD_WIDTH +: COORD_WIDTH];
    return e;
  endfunction

  // nearest integer of v / 2^sh, ties away from zero
  function automatic longint round_away(longint v, int sh);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -q : q;
  endfunction

  function automatic bit predict_match(coord_t px, coord_t py, coord_t pz);
    longint cand [3];
    longint diff [3];
    longint resid [3];
    longint cart [3];
    longint frac, whole, acc, dist_sq, lhs, rhs;
    cand[0] = px;
    cand[1] = py;
    cand[2] = pz;
    for (int i = 0; i < 3; i++)
      diff[i] = reg_field(int'(REG_REFERENCE_POSITION), i) - cand[i];
    // fractional coords, reduced to the nearest image
    for (int i = 0; i < 3; i++) begin
      frac = 0;
      for (int j = 0; j < 3; j++)
        frac += reg_field(int'(REG_INVERSE_ROW_0) + i, j) * diff[j];
      whole = round_away(frac, FRAC_SUM);
      resid[i] = frac - (whole <<< FRAC_SUM);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += reg_field(int'(REG_LATTICE_ROW_0) + i, j) * resid[j];
      cart[i] = round_away(acc, FRAC_SUM);
    end
    dist_sq = 0;
    for (int i = 0; i < 3; i++)
      dist_sq += cart[i] * cart[i];
    lhs = dist_sq;
    rhs = longint'(regs[REG_TOLERANCE_SQUARED][TOL_WIDTH-1:0]);
    if (2 * COORD_FRAC_BITS >= TOL_FRAC_BITS)
      rhs = rhs <<< (2 * COORD_FRAC_BITS - TOL_FRAC_BITS);
    else
      lhs = lhs <<< (TOL_FRAC_BITS - 2 * COORD_FRAC_BITS);
    return lhs < rhs;
  endfunction

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++)
        regs[r] = '0;
      expected_match.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready)
        regs[cfg.index] = cfg.data;
      if (site.valid && site.ready)
        expected_match.push_back(predict_match(site.position_x, site.position_y,
                                               site.position_z));
      if (result.valid && result.ready) begin
        if (expected_match.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got is_match=%b",
                   $time, result.is_match);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_match.pop_front();
          if (result.is_match !== want) begin
            $display("%0t: is_match mismatch, expected %b, got %b",
                     $time, want, result.is_match);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_match.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
  import psm_pkg::*;

  localparam int  NUM_REGS    = 8;
  localparam int  LONG_HOLD   = 120;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  NUM_PHASES  = 10;
  localparam int  PHASE_ITEMS = 104;
  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_WIDTH - 1));

  typedef enum int {TOL_RANDOM, TOL_ZERO, TOL_MAX, RAW_REGS} phase_kind_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   noise_radius;
  bit   tx_idle;
  bit   rx_idle;
  bit   hold_request;
  bit   hold_done;
  logic [CFG_DATA_WIDTH-1:0] reg_image [NUM_REGS];

  psm_pos_if   site ();
  psm_match_if result ();
  psm_cfg_if   cfg ();

  periodic_site_match DUT (
    .clk    (clk),
    .rst    (rst),
    .site   (site),
    .result (result),
    .cfg    (cfg)
  );

  site_match_checker match_check (
    .clk         (clk),
    .rst         (rst),
    .site        (site),
    .result      (result),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("periodic_site_match test failed");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
  endfunction

  function automatic longint reg_entry(int r, int j);
    coord_t e;
    e = reg_image[r][j*COORD_WIDTH +: COORD_WIDTH];
    return e;
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pack_entries(longint a, longint b,
                                                            longint c);
    return {coord_t'(c), coord_t'(b), coord_t'(a)};
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] random_bits60();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[CFG_DATA_WIDTH-1:0];
  endfunction

  task automatic send_position(longint x, longint y, longint z);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      site.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    site.valid      <= 1'b1;
    site.position_x <= coord_t'(x);
    site.position_y <= coord_t'(y);
    site.position_z <= coord_t'(z);
    do @(posedge clk); while (!site.ready);
  endtask

  // ref plus an offset, for the directed checks
  task automatic send_offset(longint dx, longint dy, longint dz);
    send_position(reg_entry(REG_REFERENCE_POSITION, 0) + dx,
                  reg_entry(REG_REFERENCE_POSITION, 1) + dy,
                  reg_entry(REG_REFERENCE_POSITION, 2) + dz);
  endtask

  // reference site shifted by a few whole lattice vectors, plus jitter
  task automatic send_lattice_image();
    longint pos [3];
    longint jitter [3];
    int     cells [3];
    bit     fits;
    fits = 1'b1;
    for (int j = 0; j < 3; j++) begin
      cells[j]  = int'($urandom_range(0, 6)) - 3;
      jitter[j] = longint'($urandom_range(0, 2 * noise_radius)) - noise_radius;
    end
    for (int i = 0; i < 3; i++) begin
      pos[i] = reg_entry(REG_REFERENCE_POSITION, i) + jitter[i];
      for (int j = 0; j < 3; j++)
        pos[i] += reg_entry(int'(REG_LATTICE_ROW_0) + i, j) * cells[j];
      if (pos[i] > COORD_MAX || pos[i] < COORD_MIN)
        fits = 1'b0;
    end
    if (!fits)
      for (int i = 0; i < 3; i++)
        pos[i] = clamp_coord(reg_entry(REG_REFERENCE_POSITION, i) + jitter[i]);
    send_position(pos[0], pos[1], pos[2]);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic load_registers();
    for (int r = 0; r < NUM_REGS; r++)
      write_reg(cfg_reg_t'(r), reg_image[r]);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    site.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // random skewed cell with its inverse, built in floating point
  task automatic make_lattice(phase_kind_t kind);
    real    lat [3][3];
    real    det, cof, scaled;
    longint q [3][3];
    longint inv [3][3];
    logic [TOL_WIDTH-1:0] tol;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (i == j)
          q[i][j] = $urandom_range(3072, 10240);
        else
          q[i][j] = longint'($urandom_range(0, 3072)) - 1536;
        lat[i][j] = real'(q[i][j]);
      end
    det = lat[0][0] * (lat[1][1] * lat[2][2] - lat[1][2] * lat[2][1])
        - lat[0][1] * (lat[1][0] * lat[2][2] - lat[1][2] * lat[2][0])
        + lat[0][2] * (lat[1][0] * lat[2][1] - lat[1][1] * lat[2][0]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cof = lat[(j+1)%3][(i+1)%3] * lat[(j+2)%3][(i+2)%3]
            - lat[(j+1)%3][(i+2)%3] * lat[(j+2)%3][(i+1)%3];
        scaled = cof / det * real'(1 << (COORD_FRAC_BITS + INVERSE_FRAC_BITS));
        inv[i][j] = clamp_coord($rtoi(scaled + ((scaled >= 0.0) ? 0.5 : -0.5)));
      end
    for (int i = 0; i < 3; i++) begin
      reg_image[int'(REG_LATTICE_ROW_0) + i] = pack_entries(q[i][0], q[i][1], q[i][2]);
      reg_image[int'(REG_INVERSE_ROW_0) + i] =
        pack_entries(inv[i][0], inv[i][1], inv[i][2]);
    end
    reg_image[REG_REFERENCE_POSITION] =
      pack_entries(longint'($urandom_range(0, 409600)) - 204800,
                   longint'($urandom_range(0, 409600)) - 204800,
                   longint'($urandom_range(0, 409600)) - 204800);
    case (kind)
      TOL_ZERO: tol = '0;
      TOL_MAX:  tol = '1;
      default:  tol = $urandom_range(1000, 1 << 19);
    endcase
    // bits above the tolerance width are junk the block must drop
    reg_image[REG_TOLERANCE_SQUARED] =
      {(CFG_DATA_WIDTH - TOL_WIDTH)'(random_bits60() >> TOL_WIDTH), tol};
    noise_radius = (kind == TOL_RANDOM) ? $rtoi($sqrt(real'(tol))) : 400;
  endtask

  // receiver: short random stalls, plus one long hold-off on request
  initial begin
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        result.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    phase_kind_t kind;
    hold_request     = 1'b0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    noise_radius     = 400;
    rst             <= 1'b1;
    site.valid      <= 1'b0;
    site.position_x <= '0;
    site.position_y <= '0;
    site.position_z <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_LATTICE_ROW_0;
    cfg.data        <= '0;
    for (int r = 0; r < NUM_REGS; r++)
      reg_image[r] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: zero tolerance, never a match
    send_position(0, 0, 0);
    send_position(COORD_MAX, COORD_MAX, COORD_MAX);
    send_position(COORD_MIN, COORD_MIN, COORD_MIN);
    send_position(COORD_MIN, COORD_MAX, 0);
    drain();

    // cubic cell, 4.0 edge; tolerance is exactly 100^2 in the squared units
    for (int i = 0; i < 3; i++) begin
      reg_image[int'(REG_LATTICE_ROW_0) + i] =
        pack_entries(i == 0 ? 4096 : 0, i == 1 ? 4096 : 0, i == 2 ? 4096 : 0);
      reg_image[int'(REG_INVERSE_ROW_0) + i] =
        pack_entries(i == 0 ? 16384 : 0, i == 1 ? 16384 : 0, i == 2 ? 16384 : 0);
    end
    reg_image[REG_REFERENCE_POSITION] = pack_entries(1024, 2048, -3072);
    reg_image[REG_TOLERANCE_SQUARED]  = 60'd10000;
    load_registers();
    send_offset(0, 0, 0);
    send_offset(4096, 0, 0);
    send_offset(0, -8192, 4096);
    send_offset(2048, 0, 0);       // half cell, rounds away from zero
    send_offset(-2048, 0, 0);
    send_offset(99, 0, 0);
    send_offset(100, 0, 0);        // exactly on the tolerance: strict compare
    send_offset(0, 0, -99);
    drain();

    // extreme matrix entries, inverse unrelated to the lattice
    for (int i = 0; i < 3; i++) begin
      reg_image[int'(REG_LATTICE_ROW_0) + i] = pack_entries(COORD_MAX, COORD_MAX, COORD_MAX);
      reg_image[int'(REG_INVERSE_ROW_0) + i] = pack_entries(COORD_MIN, COORD_MIN, COORD_MIN);
    end
    reg_image[REG_REFERENCE_POSITION] = pack_entries(COORD_MAX, COORD_MIN, COORD_MAX);
    reg_image[REG_TOLERANCE_SQUARED]  = {28'd0, 32'hFFFF_FFFF};
    load_registers();
    send_position(COORD_MIN, COORD_MIN, COORD_MIN);
    send_position(COORD_MAX, COORD_MAX, COORD_MAX);
    send_position(0, 0, 0);
    drain();

    for (int r = 0; r < NUM_REGS; r++)
      reg_image[r] = '1;
    load_registers();
    send_position(COORD_MAX, COORD_MIN, 0);
    send_position(COORD_MIN, COORD_MAX, COORD_MAX);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        2, 6:    kind = RAW_REGS;
        4:       kind = TOL_ZERO;
        7:       kind = TOL_MAX;
        default: kind = TOL_RANDOM;
      endcase
      if (kind == RAW_REGS) begin
        for (int r = 0; r < NUM_REGS; r++)
          reg_image[r] = random_bits60();
        noise_radius = 1000;
      end else begin
        make_lattice(kind);
      end
      load_registers();
      tx_idle = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      rx_idle = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (p == 3)
        hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 4) == 0)
          send_position(longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
                        longint'(coord_t'($urandom)));
        else
          send_lattice_image();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("periodic_site_match test passed");
    else
      $display("periodic_site_match test failed");
    $finish;
  end

endmodule

`default_nettype wire
